// ===== hdl/hhpg_pkg.sv =====
// Package for the Halton / Hammersley point generator.
// Holds the widths, register indexes, state encodings and the job and result
// structures shared by the top level and the radical inverse core.
`default_nettype none

package hhpg_pkg;

    localparam int IDX_W      = 32;
    localparam int BASE_W     = 16;
    localparam int ACC_W      = 48;
    localparam int QUO_W      = 32;
    localparam int OUT_W      = 24;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BASE_W-1:0] MIN_BASE      = 16'd2;
    localparam logic [BASE_W-1:0] FALLBACK_BASE = 16'd47;

    localparam logic [IDX_W-1:0]  RST_BURNIN       = 32'd47;
    localparam logic [IDX_W-1:0]  RST_SAMPLE_COUNT = 32'd128;
    localparam logic [BASE_W-1:0] RST_BASE_X       = 16'd13;
    localparam logic [BASE_W-1:0] RST_BASE_Y       = 16'd47;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_BASE_X       = 3'd1,
        CFG_BASE_Y       = 3'd2,
        CFG_BURNIN       = 3'd3,
        CFG_SAMPLE_COUNT = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIGIT,
        C_MUL_P,
        C_MUL_R,
        C_FRAC,
        C_DONE
    } t_core_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_X,
        T_Y,
        T_OUT
    } t_top_state;

    typedef struct packed {
        logic              start;
        logic              frac;
        logic [IDX_W-1:0]  n;
        logic [BASE_W-1:0] base;
        logic [ACC_W-1:0]  r;
        logic [ACC_W-1:0]  p;
    } t_job;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] value;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/hhpg_core.sv =====
// Radical inverse core with one shared restoring division step and one multiplier.
// Extracts base-b digits of n, builds the mirrored numerator and b^k, then divides.
// Depends on hhpg_pkg.
`default_nettype none

module hhpg_core #(
    parameter int FRAC_BITS  = 24,
    parameter int MAX_DIGITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hhpg_pkg::t_job i_job,
    output hhpg_pkg::t_res o_res
);
    import hhpg_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_DIGITS);
    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(IDX_W);
    localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(FRAC_BITS);

    t_core_state r_state, n_state;

    logic [ACC_W-1:0]  r_rem,  n_rem;
    logic [ACC_W-1:0]  r_div,  n_div;
    logic [IDX_W-1:0]  r_num,  n_num;
    logic [QUO_W-1:0]  r_quo,  n_quo;
    logic [ACC_W-1:0]  r_r,    n_r;
    logic [ACC_W-1:0]  r_p,    n_p;
    logic [BASE_W-1:0] r_base, n_base;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [STEP_W-1:0] r_step, n_step;

    logic [ACC_W:0]            step_rem2;
    logic [ACC_W:0]            step_diff;
    logic                      step_take;
    logic [ACC_W-1:0]          mul_a;
    logic [ACC_W+BASE_W-1:0]   mul_prod;
    logic [ACC_W-1:0]          new_r;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      last_step;
    logic                      more_digits;

    assign step_rem2 = {r_rem, r_num[IDX_W-1]};
    assign step_diff = step_rem2 - {1'b0, r_div};
    assign step_take = (step_rem2 >= {1'b0, r_div});

    assign mul_a    = (r_state == C_MUL_P) ? r_p : r_r;
    assign mul_prod = {{BASE_W{1'b0}}, mul_a} * {{ACC_W{1'b0}}, r_base};
    assign new_r    = mul_prod[ACC_W-1:0] + ACC_W'(r_rem[BASE_W-1:0]);

    assign cnt_inc     = r_cnt + CNT_W'(1);
    assign last_step   = (r_step == STEP_W'(1));
    assign more_digits = (r_quo != '0) && (cnt_inc < MAX_CNT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: begin
                if (i_job.start) begin
                    if (i_job.frac || (i_job.n == '0)) begin
                        n_state = C_FRAC;
                    end else begin
                        n_state = C_DIGIT;
                    end
                end
            end
            C_DIGIT: begin
                if (last_step) begin
                    n_state = C_MUL_P;
                end
            end
            C_MUL_P: begin
                n_state = C_MUL_R;
            end
            C_MUL_R: begin
                n_state = more_digits ? C_DIGIT : C_FRAC;
            end
            C_FRAC: begin
                if (last_step) begin
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rem  = r_rem;
        n_div  = r_div;
        n_num  = r_num;
        n_quo  = r_quo;
        n_r    = r_r;
        n_p    = r_p;
        n_base = r_base;
        n_cnt  = r_cnt;
        n_step = r_step;
        case (r_state)
            C_IDLE: begin
                if (i_job.start) begin
                    n_base = i_job.base;
                    n_quo  = '0;
                    n_cnt  = '0;
                    if (i_job.frac) begin
                        n_num  = '0;
                        n_r    = i_job.r;
                        n_p    = i_job.p;
                        n_rem  = i_job.r;
                        n_div  = i_job.p;
                        n_step = FRAC_STEPS;
                    end else if (i_job.n == '0) begin
                        n_num  = '0;
                        n_r    = '0;
                        n_p    = ACC_W'(1);
                        n_rem  = '0;
                        n_div  = ACC_W'(1);
                        n_step = FRAC_STEPS;
                    end else begin
                        n_num  = i_job.n;
                        n_r    = '0;
                        n_p    = ACC_W'(1);
                        n_rem  = '0;
                        n_div  = ACC_W'(i_job.base);
                        n_step = DIV_STEPS;
                    end
                end
            end
            C_DIGIT, C_FRAC: begin
                n_rem  = step_take ? step_diff[ACC_W-1:0] : step_rem2[ACC_W-1:0];
                n_num  = {r_num[IDX_W-2:0], 1'b0};
                n_quo  = {r_quo[QUO_W-2:0], step_take};
                n_step = r_step - STEP_W'(1);
            end
            C_MUL_P: begin
                n_p = mul_prod[ACC_W-1:0];
            end
            C_MUL_R: begin
                n_r   = new_r;
                n_cnt = cnt_inc;
                n_quo = '0;
                if (more_digits) begin
                    n_rem  = '0;
                    n_num  = r_quo[IDX_W-1:0];
                    n_div  = ACC_W'(r_base);
                    n_step = DIV_STEPS;
                end else begin
                    n_rem  = new_r;
                    n_num  = '0;
                    n_div  = r_p;
                    n_step = FRAC_STEPS;
                end
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_r    <= n_r;
        r_p    <= n_p;
        r_base <= n_base;
        r_cnt  <= n_cnt;
        r_step <= n_step;
    end

    assign o_res.done  = (r_state == C_DONE);
    assign o_res.value = r_quo;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DIGIT || r_state == C_FRAC) |-> (r_rem < r_div))
        else $error("Partial remainder is not below the divisor.");

    a_digit_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_MUL_R) |-> (r_rem < ACC_W'(r_base)))
        else $error("Extracted digit is not below the base.");

    a_power_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DIGIT || r_state == C_MUL_P || r_state == C_MUL_R ||
         r_state == C_FRAC) |-> (r_p != '0))
        else $error("Denominator power has become zero.");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.start |-> (r_state == C_IDLE))
        else $error("Job started while the core was busy.");
`endif

endmodule

`default_nettype wire

// ===== hdl/halton_hammersley_point_generator_top.sv =====
// Top level of the Halton / Hammersley 2D point generator.
// Holds the configuration registers, the transaction handshakes and the output register.
// Depends on hhpg_pkg and hhpg_core.
`default_nettype none

// Each accepted sample index yields one point (x, y) as unsigned fractions with
// FRAC_BITS fraction bits, truncated, of which the low 24 bits are output. Both
// coordinates are computed one after the other by a single core that owns one
// restoring division step and one 48 by 16 bit multiplier. A radical inverse
// extracts the base digits one after the other by restoring division of n (the
// index plus the burn-in) by the base, multiplies the power and the mirrored
// numerator by the base for each digit, then performs the final fraction
// division; the uniform Hammersley axis needs only the fraction division. The
// input is not ready while a point is being computed, but a finished point may
// wait in the output register while the next index is accepted. Configuration
// must be written only while idle; the block itself does not enforce this.
module halton_hammersley_point_generator_top #(
    parameter int FRAC_BITS  = 24,
    parameter int MAX_DIGITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hhpg_pkg::IDX_W-1:0]          i_sample_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hhpg_pkg::OUT_W-1:0]          o_x_frac,
    output logic [hhpg_pkg::OUT_W-1:0]          o_y_frac,
    input  logic                                i_cfg_we,
    input  logic [hhpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hhpg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hhpg_pkg::*;

    t_top_state r_state, n_state;

    logic              r_mode;
    logic [BASE_W-1:0] r_base_x;
    logic [BASE_W-1:0] r_base_y;
    logic [IDX_W-1:0]  r_burnin;
    logic [IDX_W-1:0]  r_sample_count;

    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_n;
    logic              r_start, n_start;
    logic [OUT_W-1:0]  r_x;
    logic [OUT_W-1:0]  r_y;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_x_out;
    logic [OUT_W-1:0]  r_y_out;

    logic              in_accept;
    logic              load_out;
    logic [BASE_W-1:0] base_x_eff;
    logic [BASE_W-1:0] base_y_eff;
    logic              uniform_y;
    t_job              job;
    t_res              res;

    assign in_accept  = i_valid && o_ready;
    assign base_x_eff = (r_base_x < MIN_BASE) ? MIN_BASE : r_base_x;
    assign base_y_eff = (r_base_y < MIN_BASE) ? MIN_BASE : r_base_y;
    assign uniform_y  = r_mode && (r_idx < r_sample_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (i_valid) begin
                    n_state = T_X;
                end
            end
            T_X: begin
                if (res.done) begin
                    n_state = T_Y;
                end
            end
            T_Y: begin
                if (res.done) begin
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = (r_state == T_IDLE);
        load_out    = (r_state == T_OUT) && (!r_out_valid || i_ready);
        n_start     = in_accept || ((r_state == T_X) && res.done);
        n_out_valid = load_out || (r_out_valid && !i_ready);

        job.start = r_start;
        job.n     = r_n;
        job.r     = ACC_W'({r_idx, 1'b1});
        job.p     = ACC_W'({r_sample_count, 1'b0});
        case (r_state)
            T_X: begin
                job.frac = 1'b0;
                job.base = base_x_eff;
            end
            T_Y: begin
                job.frac = uniform_y;
                job.base = r_mode ? FALLBACK_BASE : base_y_eff;
            end
            default: begin
                job.frac = 1'b0;
                job.base = base_x_eff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= T_IDLE;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_mode         <= 1'b0;
            r_base_x       <= RST_BASE_X;
            r_base_y       <= RST_BASE_Y;
            r_burnin       <= RST_BURNIN;
            r_sample_count <= RST_SAMPLE_COUNT;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:         r_mode         <= i_cfg_data[0];
                    CFG_BASE_X:       r_base_x       <= i_cfg_data[BASE_W-1:0];
                    CFG_BASE_Y:       r_base_y       <= i_cfg_data[BASE_W-1:0];
                    CFG_BURNIN:       r_burnin       <= i_cfg_data[IDX_W-1:0];
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[IDX_W-1:0];
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_idx <= i_sample_index;
            r_n   <= i_sample_index + r_burnin;
        end
        if ((r_state == T_X) && res.done) begin
            r_x <= res.value[OUT_W-1:0];
        end
        if ((r_state == T_Y) && res.done) begin
            r_y <= res.value[OUT_W-1:0];
        end
        if (load_out) begin
            r_x_out <= r_x;
            r_y_out <= r_y;
        end
    end

    hhpg_core #(
        .FRAC_BITS  (FRAC_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_res   (res)
    );

    assign o_valid  = r_out_valid;
    assign o_x_frac = r_x_out;
    assign o_y_frac = r_y_out;

`ifndef SYNTHESIS
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> (r_state == T_X || r_state == T_Y))
        else $error("Core finished a job that the sequencer did not start.");

    a_accept_starts_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == T_X && r_start))
        else $error("Accepted transaction did not start the x coordinate.");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !load_out)
        else $error("Output register overwritten while a transaction is pending.");
`endif

endmodule

`default_nettype wire
